>>> sv/spu_pkg.sv
// ----------------------------------------------------------------------------
// spu_pkg
// Shared types and constants of the operand stack unit.
// ----------------------------------------------------------------------------
package spu_pkg;

    // Default number of stack entries
    localparam int SPU_STACK_DEPTH = 64;

    // Data word of one stack entry
    localparam int SPU_DATA_W = 32;

    // Input request: opcode (2) + push_value (32), padded to whole bytes
    localparam int SPU_OP_W      = 2;
    localparam int SPU_IN_BITS   = SPU_OP_W + SPU_DATA_W;
    localparam int SPU_IN_TDATA_W = ((SPU_IN_BITS + 7) / 8) * 8;

    typedef enum logic [SPU_OP_W-1:0] {
        OP_PUSH = 2'd0,
        OP_ADD  = 2'd1,
        OP_DIV  = 2'd2,
        OP_NOP  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_SHORT   = 2'd1,
        ST_DIVZERO = 2'd2,
        ST_FULL    = 2'd3
    } status_t;

    // Controller to datapath
    typedef struct packed {
        logic    load;        // capture push_value of an accepted request
        logic    push;        // spill top to memory, place value on top
        logic    rd_second;   // read the entry below the top
        logic    add_commit;  // top := second + top, drop one entry
        logic    div_start;   // start second / top
        logic    div_commit;  // top := quotient, drop one entry
        logic    out_load;    // load the result register
        status_t status;      // status carried with out_load
    } spu_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic full;      // depth equals capacity
        logic short_stk; // fewer than two entries
        logic top_zero;  // top entry is zero
        logic div_done;  // quotient ready this cycle
        logic out_free;  // result register may be loaded
    } spu_stat_t;

endpackage

>>> sv/stack_push_add_div_unit_core.sv
// ----------------------------------------------------------------------------
// stack_push_add_div_unit_core
// Operand stack of signed 32-bit integers executing push, add and divide.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Bits of tdata (lowest first)
//  s_       in         opcode[1:0], push_value[33:2], zero pad to 40
//  m_       out        status[1:0], top_value[33:2], stack_depth[40:34],
//                      zero pad to 48 (for the default depth of 64)
//
//  Steps per request: push, no-op and every error go from the check straight
//  to the result; add first reads the entry below the top; divide reads it,
//  then runs the one-bit-per-cycle divider (32 iterations).
//  One request is in flight at a time; s_tready is high only while idle.
//  The result register lets a new request be accepted while the previous
//  result still waits on m_tready; a held result stalls only the next
//  request's completion, never its acceptance.
//  Reset (aresetn low, synchronous) empties the stack and drops any pending
//  result; the entry memory is not cleared, as entries are read only once
//  written.
//
module stack_push_add_div_unit_core
    import spu_pkg::*;
#(
    parameter int STACK_DEPTH = SPU_STACK_DEPTH,
    parameter int DEPTH_W     = $clog2(STACK_DEPTH + 1),
    parameter int OUT_TDATA_W = ((2 + SPU_DATA_W + DEPTH_W + 7) / 8) * 8
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    // Request channel
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [SPU_IN_TDATA_W-1:0] s_tdata,  // opcode, push_value
    // Result channel
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [OUT_TDATA_W-1:0]    m_tdata   // status, top_value, stack_depth
);

    spu_cmd_t  cmd;
    spu_stat_t stat;

    // Sequence each request: check, read the second entry, operate, hand off
    spu_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Hold the stack, perform the arithmetic and drive the result channel
    spu_datapath #(
        .STACK_DEPTH (STACK_DEPTH),
        .DEPTH_W     (DEPTH_W),
        .OUT_TDATA_W (OUT_TDATA_W)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .stat     (stat),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

>>> sv/spu_ram.sv
// ----------------------------------------------------------------------------
// spu_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module spu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> sv/spu_div.sv
// ----------------------------------------------------------------------------
// spu_div
// Iterative signed 32-bit divider, one quotient bit per cycle, truncating.
// ----------------------------------------------------------------------------
module spu_div
    import spu_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [SPU_DATA_W-1:0] dividend,
    input  logic [SPU_DATA_W-1:0] divisor,
    output logic                  done,
    output logic [SPU_DATA_W-1:0] quotient
);

    localparam int CNT_W = $clog2(SPU_DATA_W);

    logic                  busy_reg, busy_next;
    logic                  fin_reg, fin_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [SPU_DATA_W-1:0] rem_reg, rem_next;
    logic [SPU_DATA_W-1:0] quo_reg, quo_next;
    logic [SPU_DATA_W-1:0] dvs_reg, dvs_next;
    logic                  neg_reg, neg_next;

    logic [SPU_DATA_W-1:0] rem_shift;
    logic [SPU_DATA_W:0]   diff;

    assign rem_shift = {rem_reg[SPU_DATA_W-2:0], quo_reg[SPU_DATA_W-1]};
    assign diff      = {1'b0, rem_shift} - {1'b0, dvs_reg};

    always_comb begin
        busy_next = busy_reg;
        fin_next  = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        neg_next  = neg_reg;
        if (start) begin
            // Magnitudes; the most negative value maps onto 2^31 unsigned
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = dividend[SPU_DATA_W-1] ? (~dividend + 1'b1) : dividend;
            dvs_next  = divisor[SPU_DATA_W-1] ? (~divisor + 1'b1) : divisor;
            neg_next  = dividend[SPU_DATA_W-1] ^ divisor[SPU_DATA_W-1];
        end else if (busy_reg) begin
            if (!diff[SPU_DATA_W]) begin
                rem_next = diff[SPU_DATA_W-1:0];
                quo_next = {quo_reg[SPU_DATA_W-2:0], 1'b1};
            end else begin
                rem_next = rem_shift;
                quo_next = {quo_reg[SPU_DATA_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(SPU_DATA_W - 1)) begin
                busy_next = 1'b0;
                fin_next  = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            fin_reg  <= fin_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
        neg_reg <= neg_next;
    end

    assign done     = fin_reg;
    assign quotient = neg_reg ? (~quo_reg + 1'b1) : quo_reg;

endmodule

>>> sv/spu_datapath.sv
// ----------------------------------------------------------------------------
// spu_datapath
// Top-of-stack register, entry memory, adder, divider and result register.
// ----------------------------------------------------------------------------
module spu_datapath
    import spu_pkg::*;
#(
    parameter int STACK_DEPTH = SPU_STACK_DEPTH,
    parameter int DEPTH_W     = $clog2(STACK_DEPTH + 1),
    parameter int OUT_TDATA_W = ((2 + SPU_DATA_W + DEPTH_W + 7) / 8) * 8
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  spu_cmd_t                  cmd,
    output spu_stat_t                 stat,
    input  logic [SPU_IN_TDATA_W-1:0] s_tdata,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [OUT_TDATA_W-1:0]    m_tdata
);

    localparam int ADDR_W = $clog2(STACK_DEPTH);
    localparam int PAD_W  = OUT_TDATA_W - (2 + SPU_DATA_W + DEPTH_W);

    logic [SPU_DATA_W-1:0]  val_reg;
    logic [SPU_DATA_W-1:0]  top_reg;
    logic [DEPTH_W-1:0]     depth_reg;
    logic                   m_tvalid_reg;
    logic [OUT_TDATA_W-1:0] m_tdata_reg;

    logic                   ram_we;
    logic [ADDR_W-1:0]      ram_addr;
    logic [SPU_DATA_W-1:0]  second;
    logic [DEPTH_W-1:0]     depth_m1;
    logic [DEPTH_W-1:0]     depth_m2;
    logic                   div_done;
    logic [SPU_DATA_W-1:0]  div_quo;
    logic [SPU_DATA_W-1:0]  top_out;

    // Memory holds every entry below the top; the top lives in top_reg
    assign depth_m1 = depth_reg - DEPTH_W'(1);
    assign depth_m2 = depth_reg - DEPTH_W'(2);
    assign ram_we   = cmd.push && (depth_reg != '0);
    assign ram_addr = cmd.push ? depth_m1[ADDR_W-1:0] : depth_m2[ADDR_W-1:0];

    spu_ram #(
        .WIDTH (SPU_DATA_W),
        .DEPTH (STACK_DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .re    (cmd.rd_second),
        .addr  (ram_addr),
        .wdata (top_reg),
        .rdata (second)
    );

    spu_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (second),
        .divisor  (top_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            depth_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cmd.push) begin
                depth_reg <= depth_reg + DEPTH_W'(1);
            end else if (cmd.add_commit || cmd.div_commit) begin
                depth_reg <= depth_m1;
            end
            if (cmd.out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
        if (cmd.load) begin
            val_reg <= s_tdata[SPU_OP_W +: SPU_DATA_W];
        end
        if (cmd.push) begin
            top_reg <= val_reg;
        end else if (cmd.add_commit) begin
            top_reg <= second + top_reg;
        end else if (cmd.div_commit) begin
            top_reg <= div_quo;
        end
        if (cmd.out_load) begin
            m_tdata_reg <= {{PAD_W{1'b0}}, depth_reg, top_out, cmd.status};
        end
    end

    assign top_out = (depth_reg == '0) ? '0 : top_reg;

    assign stat.full      = (depth_reg == DEPTH_W'(STACK_DEPTH));
    assign stat.short_stk = (depth_reg < DEPTH_W'(2));
    assign stat.top_zero  = (top_reg == '0);
    assign stat.div_done  = div_done;
    assign stat.out_free  = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

>>> sv/spu_ctrl.sv
// ----------------------------------------------------------------------------
// spu_ctrl
// Instruction sequencer: checks, memory read, add or divide, result hand-off.
// ----------------------------------------------------------------------------
module spu_ctrl
    import spu_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [SPU_IN_TDATA_W-1:0] s_tdata,
    input  spu_stat_t                 stat,
    output spu_cmd_t                  cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_READ,
        S_DIV,
        S_RESULT
    } state_t;

    state_t  state_reg, state_next;
    op_t     op_reg, op_next;
    status_t status_reg, status_next;
    logic    accept;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        state_next  = state_reg;
        op_next     = op_reg;
        status_next = status_reg;
        cmd         = '0;
        cmd.status  = status_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    cmd.load   = 1'b1;
                    op_next    = op_t'(s_tdata[SPU_OP_W-1:0]);
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                status_next = ST_OK;
                state_next  = S_RESULT;
                unique case (op_reg)
                    OP_PUSH: begin
                        if (stat.full) begin
                            status_next = ST_FULL;
                        end else begin
                            cmd.push = 1'b1;
                        end
                    end
                    OP_ADD, OP_DIV: begin
                        // Too-short check takes precedence over divide by zero
                        if (stat.short_stk) begin
                            status_next = ST_SHORT;
                        end else if (op_reg == OP_DIV && stat.top_zero) begin
                            status_next = ST_DIVZERO;
                        end else begin
                            cmd.rd_second = 1'b1;
                            state_next    = S_READ;
                        end
                    end
                    OP_NOP: begin
                    end
                    default: begin
                    end
                endcase
            end
            S_READ: begin
                if (op_reg == OP_ADD) begin
                    cmd.add_commit = 1'b1;
                    state_next     = S_RESULT;
                end else begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end
            end
            S_DIV: begin
                if (stat.div_done) begin
                    cmd.div_commit = 1'b1;
                    state_next     = S_RESULT;
                end
            end
            S_RESULT: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            op_reg     <= OP_NOP;
            status_reg <= ST_OK;
        end else begin
            state_reg  <= state_next;
            op_reg     <= op_next;
            status_reg <= status_next;
        end
    end

endmodule

>>> test/stack_result_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// stack_result_checker
// Watches the request and result channels of the operand stack unit, keeps
// its own copy of the stack, predicts every result and compares it field by
// field with what the unit returns.
// ----------------------------------------------------------------------------
module stack_result_checker
    import spu_pkg::*;
#(
    parameter int STACK_DEPTH = SPU_STACK_DEPTH,
    parameter int DEPTH_W     = $clog2(STACK_DEPTH + 1),
    parameter int OUT_TDATA_W = ((2 + SPU_DATA_W + DEPTH_W + 7) / 8) * 8
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    input  logic                      s_tready,
    input  logic [SPU_IN_TDATA_W-1:0] s_tdata,
    input  logic                      m_tvalid,
    input  logic                      m_tready,
    input  logic [OUT_TDATA_W-1:0]    m_tdata,
    output int                        fail_count,
    output int                        results_checked,
    output int                        pending,
    output int                        model_depth,
    output int                        deepest,
    output int                        short_seen,
    output int                        divzero_seen,
    output int                        full_seen
);

    typedef struct packed {
        status_t               status;
        logic [SPU_DATA_W-1:0] top;
        logic [DEPTH_W-1:0]    depth;
    } stack_result_t;

    logic [SPU_DATA_W-1:0] entries [STACK_DEPTH];
    int                    held;
    stack_result_t         expected_results [$];

    // Apply one instruction to the local stack and return the result it gives
    function automatic stack_result_t execute_request(input op_t op,
                                                      input logic [SPU_DATA_W-1:0] operand);
        stack_result_t         r;
        logic [SPU_DATA_W-1:0] top_e;
        logic [SPU_DATA_W-1:0] second_e;
        longint                quo;
        r.status = ST_OK;
        case (op)
            OP_PUSH: begin
                if (held >= STACK_DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    entries[held] = operand;
                    held++;
                end
            end
            OP_ADD, OP_DIV: begin
                if (held < 2) begin
                    r.status = ST_SHORT;
                end else begin
                    top_e    = entries[held-1];
                    second_e = entries[held-2];
                    if (op == OP_ADD) begin
                        entries[held-2] = second_e + top_e;
                        held--;
                    end else if (top_e == '0) begin
                        r.status = ST_DIVZERO;
                    end else begin
                        // wide division so that the most negative by -1 wraps cleanly
                        quo = longint'($signed(second_e)) / longint'($signed(top_e));
                        entries[held-2] = quo[SPU_DATA_W-1:0];
                        held--;
                    end
                end
            end
            default: ;
        endcase
        r.top   = (held > 0) ? entries[held-1] : '0;
        r.depth = DEPTH_W'(held);
        return r;
    endfunction

    // Count a failure and say whether it is still worth a report line
    function automatic bit count_failure();
        fail_count++;
        return (fail_count <= 10);
    endfunction

    always @(posedge aclk) begin : monitor
        stack_result_t got;
        stack_result_t want;
        if (!aresetn) begin
            held = 0;
            expected_results.delete();
            fail_count      = 0;
            results_checked = 0;
            deepest         = 0;
            short_seen      = 0;
            divzero_seen    = 0;
            full_seen       = 0;
        end else begin
            // results first: a result never belongs to a request accepted at the same edge
            if (m_tvalid && m_tready) begin
                got.status = status_t'(m_tdata[1:0]);
                got.top    = m_tdata[2 +: SPU_DATA_W];
                got.depth  = m_tdata[2 + SPU_DATA_W +: DEPTH_W];
                results_checked++;
                case (got.status)
                    ST_SHORT:   short_seen++;
                    ST_DIVZERO: divzero_seen++;
                    ST_FULL:    full_seen++;
                    default: ;
                endcase
                if (expected_results.size() == 0) begin
                    if (count_failure())
                        $display("result %0d unexpected: status %0d top %h depth %0d",
                                 results_checked, got.status, got.top, got.depth);
                end else begin
                    want = expected_results.pop_front();
                    if (got !== want) begin
                        if (count_failure()) begin
                            $display("result %0d mismatch: expected status %0d top %h depth %0d",
                                     results_checked, want.status, want.top, want.depth);
                            $display("    got status %0d top %h depth %0d",
                                     got.status, got.top, got.depth);
                        end
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                expected_results.push_back(execute_request(op_t'(s_tdata[SPU_OP_W-1:0]),
                                                           s_tdata[SPU_OP_W +: SPU_DATA_W]));
                if (held > deepest)
                    deepest = held;
            end
        end
        // these two are read by the stimulus while running, so hand them over cleanly
        pending     <= expected_results.size();
        model_depth <= held;
    end

endmodule

>>> test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives instructions into the operand stack unit: a directed opening over
// the edge cases, then phases of filling, draining, division corners and
// mixed traffic, with random idling on both channels. The checker beside
// the unit predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;
    import spu_pkg::*;

    localparam int DEPTH_W         = $clog2(SPU_STACK_DEPTH + 1);
    localparam int OUT_TDATA_W     = ((2 + SPU_DATA_W + DEPTH_W + 7) / 8) * 8;
    localparam int RANDOM_REQUESTS = 1650;
    localparam int WATCHDOG_LIMIT  = 1000;  // cycles with no handshake on either side
    localparam int DRAIN_CYCLES    = 40;    // a divide plus margin

    localparam logic [SPU_DATA_W-1:0] INT_MIN   = 32'h8000_0000;
    localparam logic [SPU_DATA_W-1:0] INT_MAX   = 32'h7FFF_FFFF;
    localparam logic [SPU_DATA_W-1:0] MINUS_ONE = 32'hFFFF_FFFF;

    logic                      aclk = 1'b0;
    logic                      aresetn;
    logic                      s_tvalid;
    logic                      s_tready;
    logic [SPU_IN_TDATA_W-1:0] s_tdata;   // opcode, push_value
    logic                      m_tvalid;
    logic                      m_tready;
    logic [OUT_TDATA_W-1:0]    m_tdata;   // status, top_value, stack_depth

    // set during the stretch in which neither side idles
    logic no_idle = 1'b0;

    int fail_count;
    int results_checked;
    int pending;
    int model_depth;
    int deepest;
    int short_seen;
    int divzero_seen;
    int full_seen;
    int sent_by_op [4];
    int counted;

    stack_push_add_div_unit_core u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    stack_result_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .fail_count      (fail_count),
        .results_checked (results_checked),
        .pending         (pending),
        .model_depth     (model_depth),
        .deepest         (deepest),
        .short_seen      (short_seen),
        .divzero_seen    (divzero_seen),
        .full_seen       (full_seen)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Result side: stall about one cycle in five, never during the quiet stretch
    initial begin
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            m_tready <= no_idle || ($urandom_range(0, 99) >= 21);
        end
    end

    // Watchdog: end the run if nothing moves on either channel for too long
    initial begin : watchdog
        int stuck;
        stuck = 0;
        while (stuck < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                stuck = 0;
            else
                stuck++;
        end
        $display("watchdog: no handshake for %0d cycles, %0d results still expected",
                 WATCHDOG_LIMIT, pending);
        $display("== FAIL ==");
        $finish;
    end

    // Half random words, then small signed numbers and the usual corner values
    function automatic logic [SPU_DATA_W-1:0] pick_operand();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return $urandom();
            5, 6:          return $urandom_range(0, 16) - 8;
            default: begin
                case ($urandom_range(0, 6))
                    0:       return '0;
                    1:       return 32'd1;
                    2:       return MINUS_ONE;
                    3:       return INT_MIN;
                    4:       return INT_MAX;
                    5:       return INT_MIN + 32'd1;
                    default: return 32'd1 << $urandom_range(0, 31);
                endcase
            end
        endcase
    endfunction

    // Choose an opcode; whatever is left after push and divide goes to add,
    // with a thin slice of no-ops
    function automatic op_t pick_op(input int push_pct, input int div_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < push_pct)
            return OP_PUSH;
        else if (r < push_pct + div_pct)
            return OP_DIV;
        else if (r >= 97)
            return OP_NOP;
        else
            return OP_ADD;
    endfunction

    // Offer one request, idling first at random, and hold it until accepted
    task automatic send_request(input op_t op, input logic [SPU_DATA_W-1:0] value);
        int gap;
        gap = 0;
        if (!no_idle && $urandom_range(0, 99) < 21)
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 45) : $urandom_range(1, 6);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(SPU_IN_TDATA_W - SPU_IN_BITS){1'b0}}, value, op};
        do @(posedge aclk); while (!s_tready);
        sent_by_op[op]++;
    endtask

    // Random request with fitting content; no-ops do not advance the count
    task automatic issue(input op_t op);
        send_request(op, (op == OP_PUSH) ? pick_operand() : $urandom());
        if (op != OP_NOP)
            counted++;
    endtask

    initial begin : stimulus
        int  phase;
        int  extra;
        int  len;
        int  total;
        bit  first;

        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        counted = 0;
        first   = 1'b1;
        for (int k = 0; k < 4; k++)
            sent_by_op[k] = 0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed opening: too-short stack, wrapping add, most negative by -1,
        // divide by zero (after the short check), no-ops, truncation toward zero
        send_request(OP_ADD,  $urandom());
        send_request(OP_DIV,  $urandom());
        send_request(OP_NOP,  $urandom());
        send_request(OP_PUSH, INT_MAX);
        send_request(OP_ADD,  $urandom());
        send_request(OP_DIV,  $urandom());
        send_request(OP_PUSH, 32'd1);
        send_request(OP_ADD,  $urandom());
        send_request(OP_PUSH, MINUS_ONE);
        send_request(OP_DIV,  $urandom());
        send_request(OP_PUSH, '0);
        send_request(OP_DIV,  $urandom());
        send_request(OP_NOP,  $urandom());
        send_request(OP_ADD,  $urandom());
        send_request(OP_PUSH, -32'sd7);
        send_request(OP_PUSH, 32'd2);
        send_request(OP_DIV,  $urandom());
        send_request(OP_PUSH, INT_MIN);
        send_request(OP_ADD,  $urandom());
        send_request(OP_PUSH, INT_MAX);
        send_request(OP_DIV,  $urandom());
        send_request(OP_DIV,  $urandom());
        send_request(OP_ADD,  $urandom());
        send_request(OP_ADD,  $urandom());

        // Random phases; open with a fill so the full stack is met early
        while (counted < RANDOM_REQUESTS) begin
            no_idle <= (counted >= 700 && counted < 950);
            phase = first ? 0 : $urandom_range(0, 99);
            first = 1'b0;
            len   = $urandom_range(8, 40);
            if (phase < 20) begin
                // fill to the top, then keep pushing into the full stack a little
                extra = $urandom_range(1, 4);
                while (extra > 0 && counted < RANDOM_REQUESTS) begin
                    issue(pick_op(92, 4));
                    if (model_depth >= SPU_STACK_DEPTH)
                        extra--;
                end
            end else if (phase < 40) begin
                // drain down to one entry or none, then a few short-stack errors
                extra = $urandom_range(1, 3);
                while (extra > 0 && counted < RANDOM_REQUESTS) begin
                    issue(pick_op(6, 40));
                    if (model_depth < 2)
                        extra--;
                end
            end else if (phase < 55) begin
                // division corners: two fresh operands, then divide
                repeat (len / 4) begin
                    issue(OP_PUSH);
                    issue(OP_PUSH);
                    issue(OP_DIV);
                end
            end else begin
                repeat (len) issue(pick_op(45, 22));
            end
        end
        no_idle <= 1'b0;
        s_tvalid <= 1'b0;

        // let the last acceptance register, then drain every expected result
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        total = sent_by_op[OP_PUSH] + sent_by_op[OP_ADD] + sent_by_op[OP_DIV]
              + sent_by_op[OP_NOP];
        $display("Sent %0d: %0d push, %0d add, %0d div, %0d nop; %0d results checked.",
                 total, sent_by_op[OP_PUSH], sent_by_op[OP_ADD], sent_by_op[OP_DIV],
                 sent_by_op[OP_NOP], results_checked);
        $display("Errors: %0d short, %0d divide by zero, %0d full; deepest stack %0d of %0d.",
                 short_seen, divzero_seen, full_seen, deepest, SPU_STACK_DEPTH);
        if (fail_count == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d failures, %0d results never arrived", fail_count, pending);
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
